>>> rtl/sccr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sccr_pkg
// Shared constants, select codes, ramp colors and the square root step for
// the scalar to color ramp unit.
// ----------------------------------------------------------------------------
package sccr_pkg;

    localparam int NUM_LEVELS   = 17;
    localparam int STEP_DIVISOR = 18;
    localparam int NUM_THR      = NUM_LEVELS - 1;
    localparam int DW           = 32;
    localparam int SUM_W        = 64;
    localparam int PW           = 40;
    localparam int RANGE_W      = DW + 1;
    localparam int LVL_W        = 5;
    localparam int SQ_STAGES    = 16;
    localparam int REM_W        = 36;

    localparam logic [3:0] QS_NONE    = 4'd0;
    localparam logic [3:0] QS_POS_MAG = 4'd1;
    localparam logic [3:0] QS_POS_X   = 4'd2;
    localparam logic [3:0] QS_POS_Y   = 4'd3;
    localparam logic [3:0] QS_POS_Z   = 4'd4;
    localparam logic [3:0] QS_VEL_MAG = 4'd5;
    localparam logic [3:0] QS_VEL_X   = 4'd6;
    localparam logic [3:0] QS_VEL_Y   = 4'd7;
    localparam logic [3:0] QS_VEL_Z   = 4'd8;

    localparam logic [1:0] CFG_QSEL = 2'd0;
    localparam logic [1:0] CFG_MIN  = 2'd1;
    localparam logic [1:0] CFG_MAX  = 2'd2;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DW-1:0]    root;
    } t_sq_acc;

    function automatic logic [23:0] ramp_color(input logic [LVL_W-1:0] lvl);
        logic [23:0] c;
        case (lvl)
            5'd0:    c = 24'h0000FF;
            5'd1:    c = 24'h003FFF;
            5'd2:    c = 24'h007FFF;
            5'd3:    c = 24'h00BFFF;
            5'd4:    c = 24'h00FFFF;
            5'd5:    c = 24'h00FFBF;
            5'd6:    c = 24'h00FF7F;
            5'd7:    c = 24'h00FF3F;
            5'd8:    c = 24'h00FF00;
            5'd9:    c = 24'h3FFF00;
            5'd10:   c = 24'h7FFF00;
            5'd11:   c = 24'hBFFF00;
            5'd12:   c = 24'hFFFF00;
            5'd13:   c = 24'hFFBF00;
            5'd14:   c = 24'hFF7F00;
            5'd15:   c = 24'hFF3F00;
            default: c = 24'hFF0000;
        endcase
        return c;
    endfunction

    // One digit of the restoring square root: two radicand bits enter.
    function automatic t_sq_acc isq_step(input t_sq_acc a, input logic [1:0] b);
        t_sq_acc          r;
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        cur   = {a.rem[REM_W-3:0], b};
        trial = {2'b00, a.root, 2'b01};
        if (cur >= trial) begin
            r.rem  = cur - trial;
            r.root = {a.root[DW-2:0], 1'b1};
        end else begin
            r.rem  = cur;
            r.root = {a.root[DW-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/scalar_to_color_ramp_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scalar_to_color_ramp_unit
// Colors one particle per item with a quantized 17-level ramp.
// Start reaches the o_valid strobe through the 16-stage square root
// pipeline plus three stages on each side of it.
// Throughput: one item per cycle; busy is always low and results cannot stall.
// Reset is synchronous and active low; the select resets to velocity magnitude.
// ----------------------------------------------------------------------------
module scalar_to_color_ramp_unit
    import sccr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_idx,
    input  wire logic [DW-1:0]        i_cfg_data,
    input  wire logic signed [DW-1:0] i_pos_x,
    input  wire logic signed [DW-1:0] i_pos_y,
    input  wire logic signed [DW-1:0] i_pos_z,
    input  wire logic signed [DW-1:0] i_vel_x,
    input  wire logic signed [DW-1:0] i_vel_y,
    input  wire logic signed [DW-1:0] i_vel_z,
    output logic                      o_valid,
    output logic [LVL_W-1:0]          o_level,
    output logic [7:0]                o_red,
    output logic [7:0]                o_green,
    output logic [7:0]                o_blue
);

    logic [3:0]                r_qsel;
    logic signed [DW-1:0]      r_min;
    logic signed [DW-1:0]      r_max;
    logic signed [RANGE_W-1:0] r_range;

    logic                 s_valid, q_valid;
    logic                 s_mag, q_mag;
    logic signed [DW-1:0] s_comp, q_comp;
    logic [SUM_W-1:0]     s_sum;
    logic [DW-1:0]        q_root;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qsel  <= QS_VEL_MAG;
            r_min   <= '0;
            r_max   <= '0;
            r_range <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_QSEL: r_qsel <= i_cfg_data[3:0];
                CFG_MIN: begin
                    r_min   <= i_cfg_data;
                    r_range <= RANGE_W'(r_max) - RANGE_W'($signed(i_cfg_data));
                end
                CFG_MAX: begin
                    r_max   <= i_cfg_data;
                    r_range <= RANGE_W'($signed(i_cfg_data)) - RANGE_W'(r_min);
                end
                default: r_qsel <= r_qsel;
            endcase
        end
    end

    sccr_ssq u_ssq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_qsel  (r_qsel),
        .i_pos_x (i_pos_x),
        .i_pos_y (i_pos_y),
        .i_pos_z (i_pos_z),
        .i_vel_x (i_vel_x),
        .i_vel_y (i_vel_y),
        .i_vel_z (i_vel_z),
        .o_valid (s_valid),
        .o_mag   (s_mag),
        .o_comp  (s_comp),
        .o_sum   (s_sum)
    );

    sccr_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid),
        .i_mag   (s_mag),
        .i_comp  (s_comp),
        .i_sum   (s_sum),
        .o_valid (q_valid),
        .o_mag   (q_mag),
        .o_comp  (q_comp),
        .o_root  (q_root)
    );

    sccr_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_mag   (q_mag),
        .i_comp  (q_comp),
        .i_root  (q_root),
        .i_min   (r_min),
        .i_range (r_range),
        .o_valid (o_valid),
        .o_level (o_level),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

endmodule
`default_nettype wire

>>> rtl/sccr_ssq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sccr_ssq
// Picks the component or the vector of an item, squares the absolute
// components and sums them over three register stages.
// ----------------------------------------------------------------------------
module sccr_ssq
    import sccr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [3:0]           i_qsel,
    input  wire logic signed [DW-1:0] i_pos_x,
    input  wire logic signed [DW-1:0] i_pos_y,
    input  wire logic signed [DW-1:0] i_pos_z,
    input  wire logic signed [DW-1:0] i_vel_x,
    input  wire logic signed [DW-1:0] i_vel_y,
    input  wire logic signed [DW-1:0] i_vel_z,
    output logic                      o_valid,
    output logic                      o_mag,
    output logic signed [DW-1:0]      o_comp,
    output logic [SUM_W-1:0]          o_sum
);

    logic                 n_v1;
    logic                 n_mag1;
    logic signed [DW-1:0] n_comp1;
    logic [DW-1:0]        n_a [3];
    logic signed [DW-1:0] vsel [3];

    logic                 r_v1, r_v2, r_v3;
    logic                 r_mag1, r_mag2, r_mag3;
    logic signed [DW-1:0] r_comp1, r_comp2, r_comp3;
    logic [DW-1:0]        r_a [3];
    logic [SUM_W-1:0]     r_sq [3];
    logic [SUM_W-1:0]     r_sum;

    always_comb begin
        n_v1    = i_valid && (i_qsel != QS_NONE);
        n_mag1  = 1'b0;
        n_comp1 = '0;
        vsel[0] = i_vel_x;
        vsel[1] = i_vel_y;
        vsel[2] = i_vel_z;
        unique case (i_qsel)
            QS_POS_MAG: begin
                n_mag1  = 1'b1;
                vsel[0] = i_pos_x;
                vsel[1] = i_pos_y;
                vsel[2] = i_pos_z;
            end
            QS_VEL_MAG: n_mag1 = 1'b1;
            QS_POS_X:   n_comp1 = i_pos_x;
            QS_POS_Y:   n_comp1 = i_pos_y;
            QS_POS_Z:   n_comp1 = i_pos_z;
            QS_VEL_X:   n_comp1 = i_vel_x;
            QS_VEL_Y:   n_comp1 = i_vel_y;
            QS_VEL_Z:   n_comp1 = i_vel_z;
            default:    n_comp1 = '0;
        endcase
        for (int i = 0; i < 3; i++) begin
            n_a[i] = vsel[i][DW-1] ? (~vsel[i] + 1'b1) : vsel[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag1  <= n_mag1;
        r_comp1 <= n_comp1;
        r_mag2  <= r_mag1;
        r_comp2 <= r_comp1;
        r_mag3  <= r_mag2;
        r_comp3 <= r_comp2;
        for (int i = 0; i < 3; i++) begin
            r_a[i]  <= n_a[i];
            r_sq[i] <= SUM_W'(r_a[i]) * SUM_W'(r_a[i]);
        end
        r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
    end

    assign o_valid = r_v3;
    assign o_mag   = r_mag3;
    assign o_comp  = r_comp3;
    assign o_sum   = r_sum;

endmodule
`default_nettype wire

>>> rtl/sccr_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sccr_isqrt
// Pipelined floor square root of the 64-bit sum, two result bits per stage.
// The selected component travels alongside for component modes.
// ----------------------------------------------------------------------------
module sccr_isqrt
    import sccr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic                 i_mag,
    input  wire logic signed [DW-1:0] i_comp,
    input  wire logic [SUM_W-1:0]     i_sum,
    output logic                      o_valid,
    output logic                      o_mag,
    output logic signed [DW-1:0]      o_comp,
    output logic [DW-1:0]             o_root
);

    logic                 r_v    [SQ_STAGES];
    logic                 r_mag  [SQ_STAGES];
    logic signed [DW-1:0] r_comp [SQ_STAGES];
    logic [SUM_W-1:0]     r_x    [SQ_STAGES];
    t_sq_acc              r_acc  [SQ_STAGES];

    for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
        logic                 s_v;
        logic                 s_mag;
        logic signed [DW-1:0] s_comp;
        logic [SUM_W-1:0]     s_x;
        t_sq_acc              s_acc;
        t_sq_acc              n_acc;

        if (g == 0) begin : g_first
            assign s_v    = i_valid;
            assign s_mag  = i_mag;
            assign s_comp = i_comp;
            assign s_x    = i_sum;
            assign s_acc  = '0;
        end else begin : g_next
            assign s_v    = r_v[g-1];
            assign s_mag  = r_mag[g-1];
            assign s_comp = r_comp[g-1];
            assign s_x    = r_x[g-1];
            assign s_acc  = r_acc[g-1];
        end

        assign n_acc = isq_step(isq_step(s_acc, s_x[SUM_W-1 -: 2]), s_x[SUM_W-3 -: 2]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_mag[g]  <= s_mag;
            r_comp[g] <= s_comp;
            r_x[g]    <= {s_x[SUM_W-5:0], 4'b0000};
            r_acc[g]  <= n_acc;
        end
    end

    assign o_valid = r_v[SQ_STAGES-1];
    assign o_mag   = r_mag[SQ_STAGES-1];
    assign o_comp  = r_comp[SQ_STAGES-1];
    assign o_root  = r_acc[SQ_STAGES-1].root;

endmodule
`default_nettype wire

>>> rtl/sccr_classify.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sccr_classify
// Scales the scalar against the range, compares it with every threshold
// and looks up the level color, over three register stages.
// ----------------------------------------------------------------------------
module sccr_classify
    import sccr_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic                      i_mag,
    input  wire logic signed [DW-1:0]      i_comp,
    input  wire logic [DW-1:0]             i_root,
    input  wire logic signed [DW-1:0]      i_min,
    input  wire logic signed [RANGE_W-1:0] i_range,
    output logic                           o_valid,
    output logic [LVL_W-1:0]               o_level,
    output logic [7:0]                     o_red,
    output logic [7:0]                     o_green,
    output logic [7:0]                     o_blue
);

    logic signed [DW-1:0]      d;
    logic signed [RANGE_W-1:0] diff;
    logic signed [PW-1:0]      n_lhs;
    logic signed [PW-1:0]      kr [NUM_THR];
    logic [LVL_W-1:0]          n_level;
    logic [23:0]               rgb;

    logic                 r_va, r_vb, r_vc;
    logic signed [PW-1:0] r_lhs, r_lhs_n;
    logic [NUM_THR-1:0]   r_le;
    logic                 r_lt_top;
    logic [LVL_W-1:0]     r_level;
    logic [23:0]          r_rgb;

    // The threshold test d <= min + floor(k*range/N) is exact as N*(d-min) <= k*range.
    always_comb begin
        if (i_mag) begin
            d = i_root[DW-1] ? {1'b0, {(DW-1){1'b1}}} : i_root;
        end else begin
            d = i_comp;
        end
        diff  = RANGE_W'(d) - RANGE_W'(i_min);
        n_lhs = PW'(diff) * PW'(STEP_DIVISOR);
    end

    for (genvar j = 0; j < NUM_THR; j++) begin : g_kr
        localparam logic signed [PW-1:0] KC = PW'(j + 1);
        assign kr[j] = PW'(i_range) * KC;
    end

    always_comb begin
        n_level = '0;
        if (r_le[0]) begin
            n_level = '0;
        end else if (!r_lt_top) begin
            n_level = LVL_W'(NUM_THR);
        end else begin
            for (int i = NUM_THR - 2; i >= 1; i--) begin
                if (r_le[i]) begin
                    n_level = LVL_W'(i);
                end
            end
        end
        rgb = ramp_color(n_level);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lhs   <= n_lhs;
        r_lhs_n <= n_lhs + PW'(STEP_DIVISOR);
        for (int k = 0; k < NUM_THR; k++) begin
            r_le[k] <= (r_lhs <= kr[k]);
        end
        r_lt_top <= (r_lhs_n <= kr[NUM_THR-1]);
        r_level  <= n_level;
        r_rgb    <= rgb;
    end

    assign o_valid = r_vc;
    assign o_level = r_level;
    assign o_red   = r_rgb[23:16];
    assign o_green = r_rgb[15:8];
    assign o_blue  = r_rgb[7:0];

endmodule
`default_nettype wire

>>> bench/scalar_to_color_ramp_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_to_color_ramp_unit_test
// Self-checking bench for the scalar to color ramp unit. Particles are sent
// with random gaps under many quantity selects and color ranges; an internal
// predictor works out the level and color of each item whose select is not none,
// and every strobed result is compared in order against the oldest prediction.
// ----------------------------------------------------------------------------
module scalar_to_color_ramp_unit_test;
    import sccr_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam int         DRAIN_CYCLES = 30;

    typedef struct {
        logic [LVL_W-1:0] level;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
    } t_color;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_cfg_we = 1'b0;
    logic [1:0]           i_cfg_idx = '0;
    logic [DW-1:0]        i_cfg_data = '0;
    logic signed [DW-1:0] i_pos_x = '0;
    logic signed [DW-1:0] i_pos_y = '0;
    logic signed [DW-1:0] i_pos_z = '0;
    logic signed [DW-1:0] i_vel_x = '0;
    logic signed [DW-1:0] i_vel_y = '0;
    logic signed [DW-1:0] i_vel_z = '0;
    logic                 o_valid;
    logic [LVL_W-1:0]     o_level;
    logic [7:0]           o_red;
    logic [7:0]           o_green;
    logic [7:0]           o_blue;

    scalar_to_color_ramp_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_pos_z    (i_pos_z),
        .i_vel_x    (i_vel_x),
        .i_vel_y    (i_vel_y),
        .i_vel_z    (i_vel_z),
        .o_valid    (o_valid),
        .o_level    (o_level),
        .o_red      (o_red),
        .o_green    (o_green),
        .o_blue     (o_blue)
    );

    always #4 i_clk = ~i_clk;

    logic [23:0]          ramp_rgb [NUM_LEVELS] = '{
        24'h0000FF, 24'h003FFF, 24'h007FFF, 24'h00BFFF, 24'h00FFFF, 24'h00FFBF,
        24'h00FF7F, 24'h00FF3F, 24'h00FF00, 24'h3FFF00, 24'h7FFF00, 24'hBFFF00,
        24'hFFFF00, 24'hFFBF00, 24'hFF7F00, 24'hFF3F00, 24'hFF0000
    };

    logic [3:0]           sel_mode;
    logic signed [DW-1:0] range_lo;
    logic signed [DW-1:0] range_hi;
    longint               thr [NUM_THR];
    t_color               pending_colors [$];
    int                   mismatches = 0;
    int                   items_sent = 0;
    int                   colors_seen = 0;
    int                   level_hits [NUM_LEVELS];
    bit                   no_idle;
    bit                   done = 1'b0;

    function automatic void rebuild_thresholds();
        longint span;
        longint num;
        longint q;
        longint t;
        span = longint'(range_hi) - longint'(range_lo);
        for (int k = 1; k <= NUM_THR; k++) begin
            num = span * k;
            if (num >= 0) q = num / STEP_DIVISOR;
            else q = -((-num + STEP_DIVISOR - 1) / STEP_DIVISOR);
            t = longint'(range_lo) + q;
            if (t > 64'sd2147483647) t = 64'sd2147483647;
            if (t < -64'sd2147483648) t = -64'sd2147483648;
            thr[k-1] = t;
        end
    endfunction

    function automatic longint unsigned square_of(logic signed [DW-1:0] v);
        longint s;
        longint unsigned a;
        s = v;
        a = (s < 0) ? -s : s;
        return a * a;
    endfunction

    function automatic longint vector_length(logic signed [DW-1:0] a,
                                             logic signed [DW-1:0] b,
                                             logic signed [DW-1:0] c);
        longint unsigned x;
        longint unsigned res;
        longint unsigned bitv;
        x = square_of(a) + square_of(b) + square_of(c);
        res = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        if (res > 64'h7FFF_FFFF) res = 64'h7FFF_FFFF;
        return longint'(res);
    endfunction

    function automatic t_color color_of(longint d);
        t_color r;
        int     lvl;
        lvl = 0;
        if (d <= thr[0]) begin
            lvl = 0;
        end else if (d >= thr[NUM_THR-1]) begin
            lvl = NUM_LEVELS - 1;
        end else begin
            for (int i = 1; i < NUM_THR - 1; i++) begin
                if (d <= thr[i]) begin
                    lvl = i;
                    break;
                end
            end
        end
        r.level = lvl[LVL_W-1:0];
        {r.red, r.green, r.blue} = ramp_rgb[lvl];
        return r;
    endfunction

    // Prediction at each accepted item, from the pre-edge input values.
    always @(posedge i_clk) begin
        longint d;
        t_color c;
        if (i_rst_n && start && !busy) begin
            items_sent++;
            d = 0;
            case (sel_mode)
                QS_NONE:    d = 0;
                QS_POS_MAG: d = vector_length(i_pos_x, i_pos_y, i_pos_z);
                QS_POS_X:   d = i_pos_x;
                QS_POS_Y:   d = i_pos_y;
                QS_POS_Z:   d = i_pos_z;
                QS_VEL_MAG: d = vector_length(i_vel_x, i_vel_y, i_vel_z);
                QS_VEL_X:   d = i_vel_x;
                QS_VEL_Y:   d = i_vel_y;
                QS_VEL_Z:   d = i_vel_z;
                default:    d = 0;
            endcase
            if (sel_mode != QS_NONE) begin
                c = color_of(d);
                pending_colors.push_back(c);
            end
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("%0t: %s mismatch: got %0d expected %0d", $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_color w;
        if (i_rst_n && o_valid) begin
            if (pending_colors.size() == 0) begin
                report_mismatch("unexpected result, level", o_level, -1);
            end else begin
                w = pending_colors.pop_front();
                colors_seen++;
                if (w.level < NUM_LEVELS) level_hits[w.level]++;
                if (o_level !== w.level) report_mismatch("level", o_level, w.level);
                if (o_red !== w.red) report_mismatch("red", o_red, w.red);
                if (o_green !== w.green) report_mismatch("green", o_green, w.green);
                if (o_blue !== w.blue) report_mismatch("blue", o_blue, w.blue);
            end
        end
    end

    task automatic wait_idle();
        while (pending_colors.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [DW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_QSEL: sel_mode = data[3:0];
            CFG_MIN: begin
                range_lo = data;
                rebuild_thresholds();
            end
            CFG_MAX: begin
                range_hi = data;
                rebuild_thresholds();
            end
            default: ;
        endcase
    endtask

    task automatic configure(logic [3:0] qs, logic signed [DW-1:0] lo,
                             logic signed [DW-1:0] hi, bit spare);
        wait_idle();
        write_reg(CFG_QSEL, {28'h0, qs});
        write_reg(CFG_MIN, lo);
        write_reg(CFG_MAX, hi);
        if (spare) write_reg(CFG_SPARE, $urandom);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_particle(logic signed [DW-1:0] px, logic signed [DW-1:0] py,
                                 logic signed [DW-1:0] pz, logic signed [DW-1:0] vx,
                                 logic signed [DW-1:0] vy, logic signed [DW-1:0] vz);
        int gap;
        start   <= 1'b1;
        i_pos_x <= px;
        i_pos_y <= py;
        i_pos_z <= pz;
        i_vel_x <= vx;
        i_vel_y <= vy;
        i_vel_z <= vz;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        gap = 0;
        if (!no_idle) begin
            case ($urandom_range(0, 19))
                0:          gap = $urandom_range(10, 40);
                1, 2, 3, 4,
                5, 6, 7:    gap = $urandom_range(1, 3);
                default:    gap = 0;
            endcase
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [DW-1:0] pick_value(longint lo, longint hi);
        longint span;
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            3, 4: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            default: begin
                if (hi < lo) begin
                    span = lo;
                    lo = hi;
                    hi = span;
                end
                span = hi - lo;
                if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
                return DW'(lo + ((longint'($urandom) * span) >> 32)
                           + $urandom_range(0, 1));
            end
        endcase
    endfunction

    task automatic send_random(int count);
        logic signed [DW-1:0] v [6];
        longint               lo;
        longint               hi;
        for (int n = 0; n < count; n++) begin
            lo = range_lo;
            hi = range_hi;
            // Magnitudes are not negative: aim components at half the upper end.
            if (sel_mode == QS_POS_MAG || sel_mode == QS_VEL_MAG) begin
                lo = 0;
                hi = (range_hi > range_lo ? longint'(range_hi) : longint'(range_lo)) / 2;
                if (hi < 0) hi = -hi;
            end
            for (int j = 0; j < 6; j++) v[j] = pick_value(lo, hi);
            send_particle(v[0], v[1], v[2], v[3], v[4], v[5]);
        end
        start <= 1'b0;
    endtask

    task automatic test_reset_state();
        no_idle = 1'b0;
        send_particle(0, 0, 0, 0, 0, 0);
        send_particle(0, 0, 0, 32'sh0000_0001, 0, 0);
        send_particle(0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        start <= 1'b0;
    endtask

    task automatic test_level_sweep();
        configure(QS_VEL_X, 0, 32'sh0012_0000, 1'b1);
        for (int k = 0; k <= NUM_LEVELS; k++) begin
            send_particle(0, 0, 0, k * 32'sh0001_0000 - (k % 2), 0, 0);
        end
        start <= 1'b0;
    endtask

    task automatic test_each_select();
        configure(QS_NONE, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
        send_particle(1, 2, 3, 4, 5, 6);
        start <= 1'b0;
        for (int qs = 1; qs <= 10; qs++) begin
            configure(qs[3:0], 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
            send_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
            start <= 1'b0;
        end
        configure(QS_POS_Y, 32'sh0010_0000, -32'sh0010_0000, 1'b0);
        send_particle(0, 32'sh0008_0000, 0, 0, 0, 0);
        send_particle(0, -32'sh0008_0000, 0, 0, 0, 0);
        start <= 1'b0;
    endtask

    task automatic test_random_phases();
        logic [3:0]           qs;
        logic signed [DW-1:0] lo;
        logic signed [DW-1:0] hi;
        for (int p = 0; p < 14; p++) begin
            case ($urandom_range(0, 9))
                0:       qs = QS_NONE;
                1:       qs = 4'($urandom_range(9, 15));
                default: qs = 4'($urandom_range(1, 8));
            endcase
            case (p % 5)
                0: begin
                    lo = 32'h8000_0000;
                    hi = 32'h7FFF_FFFF;
                end
                1: begin
                    lo = $urandom;
                    hi = $urandom;
                end
                2: begin
                    lo = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
                    hi = lo + $urandom_range(0, 32'h0080_0000);
                end
                3: begin
                    lo = $urandom;
                    hi = lo;
                end
                default: begin
                    lo = $urandom_range(0, 32'h0100_0000);
                    hi = lo - $urandom_range(0, 32'h0100_0000);
                end
            endcase
            configure(qs, lo, hi, p % 4 == 0);
            no_idle = (p % 3 == 2);
            send_random(50);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        sel_mode = QS_VEL_MAG;
        range_lo = 0;
        range_hi = 0;
        rebuild_thresholds();
        foreach (level_hits[i]) level_hits[i] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_level_sweep();
        test_each_select();
        test_random_phases();
        wait_idle();
        done = 1'b1;
        $display("Sent %0d items and checked %0d colored results over all selects.",
                 items_sent, colors_seen);
        $display("Level hits 0 and 16: %0d and %0d.", level_hits[0], level_hits[16]);
        if (mismatches == 0 && pending_colors.size() == 0) begin
            $display("scalar_to_color_ramp_unit regression: pass");
        end else begin
            $display("scalar_to_color_ramp_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        if (!done) begin
            $display("Timeout with %0d results outstanding.", pending_colors.size());
            $display("scalar_to_color_ramp_unit regression: fail");
            $finish;
        end
    end

endmodule
